@@ design/sled_pkg.sv @@
// ----------------------------------------------------------------------------
// sled_pkg
// shared types, codes and byte helpers for the string literal escape decoder
// ----------------------------------------------------------------------------
package sled_pkg;

   localparam int MaxResults = 5;
   localparam int CountBits  = 3;

   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LOWER_X   = 8'h78;
   localparam logic [7:0] CHAR_LOWER_U   = 8'h75;
   localparam logic [7:0] CHAR_UPPER_U   = 8'h55;

   localparam logic [3:0] UniShortDigits = 4'd4;
   localparam logic [3:0] UniLongDigits  = 4'd8;
   localparam logic [3:0] OctDigits      = 4'd3;

   localparam logic [20:0] Utf8Lim1 = 21'h00080;
   localparam logic [20:0] Utf8Lim2 = 21'h00800;
   localparam logic [20:0] Utf8Lim3 = 21'h10000;
   localparam logic [20:0] Utf8Lim4 = 21'h110000;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_BODY  = 2'd1,
      KIND_EOS   = 2'd2,
      KIND_NONE  = 2'd3
   } item_kind_type;

   typedef enum logic [1:0] {
      RES_BYTE       = 2'd0,
      RES_END_STRING = 2'd1,
      RES_END_NAME   = 2'd2,
      RES_NL_ERROR   = 2'd3
   } result_kind_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_BODY,
      PH_ESC,
      PH_OCT,
      PH_HEX,
      PH_UNI4,
      PH_UNI8
   } phase_type;

   typedef struct packed {
      item_kind_type kind;
      logic [7:0]    data_byte;
      logic          raw_literal;
   } item_type;

   typedef struct packed {
      result_kind_type kind;
      logic [7:0]      data;
   } result_type;

   typedef struct packed {
      logic [CountBits-1:0]              count;
      result_type [MaxResults-1:0]       res;
      logic [15:0]                       line;
   } burst_type;

   function automatic burst_type push_result(burst_type bu, result_kind_type k,
                                             logic [7:0] d);
      burst_type r;
      r = bu;
      r.res[r.count].kind = k;
      r.res[r.count].data = d;
      r.count = r.count + CountBits'(1);
      return r;
   endfunction

   // {valid, value}
   function automatic logic [4:0] hex_digit(logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end
      return r;
   endfunction

   function automatic logic [7:0] escape_char(logic [7:0] b);
      logic [7:0] r;
      case (b)
         8'h61: r = 8'd7;
         8'h62: r = 8'd8;
         8'h66: r = 8'd12;
         8'h6E: r = 8'd10;
         8'h72: r = 8'd13;
         8'h74: r = 8'd9;
         8'h76: r = 8'd11;
         default: r = b;
      endcase
      return r;
   endfunction

endpackage

@@ design/sled_req_if.sv @@
// ----------------------------------------------------------------------------
// sled_req_if
// input channel: start, body byte and end of stream transactions
// ----------------------------------------------------------------------------
interface sled_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_byte;
   logic       raw_literal;

   modport source (output valid, kind, data_byte, raw_literal, input ready);
   modport sink   (input valid, kind, data_byte, raw_literal, output ready);
endinterface

@@ design/sled_rsp_if.sv @@
// ----------------------------------------------------------------------------
// sled_rsp_if
// result channel: decoded bytes and literal end markers
// ----------------------------------------------------------------------------
interface sled_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [7:0]  out_byte;
   logic [15:0] line_number;
   logic        last_of_run;

   modport source (output valid, result_kind, out_byte, line_number, last_of_run,
                   input ready);
   modport sink   (input valid, result_kind, out_byte, line_number, last_of_run,
                   output ready);
endinterface

@@ design/sled_in_reg.sv @@
// ----------------------------------------------------------------------------
// sled_in_reg
// input register, holds one transaction until the decoder takes it
// ----------------------------------------------------------------------------
module sled_in_reg (
   input  logic               clock,
   input  logic               reset,
   sled_req_if.sink           req,
   input  logic               take,
   output logic               item_valid,
   output sled_pkg::item_type item
);

   logic               valid_ff;
   logic               valid_in;
   sled_pkg::item_type item_ff;

   assign req.ready  = !valid_ff || take;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req.valid && req.ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         item_ff.kind        <= sled_pkg::item_kind_type'(req.kind);
         item_ff.data_byte   <= req.data_byte;
         item_ff.raw_literal <= req.raw_literal;
      end
   end

endmodule

@@ design/sled_decode.sv @@
// ----------------------------------------------------------------------------
// sled_decode
// literal state and escape decoding, one transaction per cycle while take is high, into a burst
// ----------------------------------------------------------------------------
module sled_decode #(
   parameter int LINE_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  sled_pkg::item_type  item,
   output sled_pkg::burst_type burst
);

   sled_pkg::phase_type  phase_ff, phase_in;
   logic [7:0]           quote_ff, quote_in;
   logic                 raw_ff, raw_in;
   logic [20:0]          esc_val_ff, esc_val_in;
   logic                 esc_big_ff, esc_big_in;
   logic [3:0]           dcnt_ff, dcnt_in;
   logic [1:0]           pq_ff, pq_in;
   logic                 swl_ff, swl_in;
   logic [LINE_BITS-1:0] line_ff, line_in;

   logic [LINE_BITS-1:0] line_inc;
   logic [15:0]          line_show;
   logic [7:0]           b;
   logic [4:0]           hx;
   logic                 is_nl;
   logic                 is_oct;
   logic [3:0]           uni_max;
   logic [20:0]          uni_shift;
   logic                 uni_shift_big;

   sled_pkg::burst_type  bst;
   logic                 do_uni;
   logic                 do_body;
   logic                 do_end;
   logic                 do_flush;
   logic                 skip;
   logic [20:0]          uni_val;
   logic                 uni_big;
   sled_pkg::result_kind_type end_kind;

   assign b        = item.data_byte;
   assign hx       = sled_pkg::hex_digit(b);
   assign is_nl    = (b == sled_pkg::CHAR_CR) || (b == sled_pkg::CHAR_LF);
   assign is_oct   = (b[7:3] == 5'b00110);
   assign line_inc = (line_ff == '1) ? line_ff : line_ff + LINE_BITS'(1);
   assign uni_max  = (phase_ff == sled_pkg::PH_UNI4) ? sled_pkg::UniShortDigits
                                                     : sled_pkg::UniLongDigits;
   assign uni_shift     = {esc_val_ff[16:0], hx[3:0]};
   assign uni_shift_big = esc_big_ff || (esc_val_ff[20:17] != 4'd0);
   assign end_kind = (quote_ff == sled_pkg::CHAR_DQUOTE) ? sled_pkg::RES_END_STRING
                                                         : sled_pkg::RES_END_NAME;

   generate
      if (LINE_BITS > 16) begin : g_line_sat
         assign line_show = (line_ff[LINE_BITS-1:16] != '0) ? 16'hFFFF : line_ff[15:0];
      end else begin : g_line_ext
         assign line_show = 16'(line_ff);
      end
   endgenerate

   always_comb begin
      phase_in   = phase_ff;
      quote_in   = quote_ff;
      raw_in     = raw_ff;
      esc_val_in = esc_val_ff;
      esc_big_in = esc_big_ff;
      dcnt_in    = dcnt_ff;
      pq_in      = pq_ff;
      swl_in     = swl_ff;
      line_in    = line_ff;
      bst        = '0;
      bst.line   = line_show;
      do_uni     = 1'b0;
      do_body    = 1'b0;
      do_end     = 1'b0;
      do_flush   = 1'b0;
      skip       = 1'b0;
      uni_val    = esc_val_ff;
      uni_big    = esc_big_ff;

      case (item.kind)
         sled_pkg::KIND_START: begin
            phase_in   = sled_pkg::PH_BODY;
            quote_in   = b;
            raw_in     = item.raw_literal;
            esc_val_in = '0;
            esc_big_in = 1'b0;
            dcnt_in    = '0;
            pq_in      = '0;
            swl_in     = 1'b0;
         end
         sled_pkg::KIND_BODY: begin
            case (phase_ff)
               sled_pkg::PH_BODY: begin
                  do_body = 1'b1;
               end
               sled_pkg::PH_ESC: begin
                  phase_in   = sled_pkg::PH_BODY;
                  esc_val_in = '0;
                  esc_big_in = 1'b0;
                  dcnt_in    = '0;
                  if (is_nl) begin
                     line_in = line_inc;
                     swl_in  = (b == sled_pkg::CHAR_CR);
                  end else if (is_oct) begin
                     esc_val_in = 21'(b[2:0]);
                     dcnt_in    = 4'd1;
                     phase_in   = sled_pkg::PH_OCT;
                  end else if (b == sled_pkg::CHAR_LOWER_X) begin
                     phase_in = sled_pkg::PH_HEX;
                  end else if (b == sled_pkg::CHAR_LOWER_U) begin
                     phase_in = sled_pkg::PH_UNI4;
                  end else if (b == sled_pkg::CHAR_UPPER_U) begin
                     phase_in = sled_pkg::PH_UNI8;
                  end else begin
                     bst = sled_pkg::push_result(bst, sled_pkg::RES_BYTE,
                                                 sled_pkg::escape_char(b));
                  end
               end
               sled_pkg::PH_OCT: begin
                  if (is_oct) begin
                     if (dcnt_ff + 4'd1 >= sled_pkg::OctDigits) begin
                        bst = sled_pkg::push_result(bst, sled_pkg::RES_BYTE,
                                                    {esc_val_ff[4:0], b[2:0]});
                        phase_in   = sled_pkg::PH_BODY;
                        esc_val_in = '0;
                        dcnt_in    = '0;
                     end else begin
                        esc_val_in = {esc_val_ff[17:0], b[2:0]};
                        dcnt_in    = dcnt_ff + 4'd1;
                     end
                  end else begin
                     bst = sled_pkg::push_result(bst, sled_pkg::RES_BYTE,
                                                 esc_val_ff[7:0]);
                     phase_in   = sled_pkg::PH_BODY;
                     esc_val_in = '0;
                     dcnt_in    = '0;
                     do_body    = 1'b1;
                  end
               end
               sled_pkg::PH_HEX: begin
                  if (hx[4]) begin
                     if (dcnt_ff == 4'd0) begin
                        esc_val_in = 21'(hx[3:0]);
                        dcnt_in    = 4'd1;
                     end else begin
                        bst = sled_pkg::push_result(bst, sled_pkg::RES_BYTE,
                                                    {esc_val_ff[3:0], hx[3:0]});
                        phase_in   = sled_pkg::PH_BODY;
                        esc_val_in = '0;
                        dcnt_in    = '0;
                     end
                  end else begin
                     bst = sled_pkg::push_result(bst, sled_pkg::RES_BYTE,
                              (dcnt_ff == 4'd0) ? sled_pkg::CHAR_LOWER_X
                                                : esc_val_ff[7:0]);
                     phase_in   = sled_pkg::PH_BODY;
                     esc_val_in = '0;
                     dcnt_in    = '0;
                     do_body    = 1'b1;
                  end
               end
               sled_pkg::PH_UNI4, sled_pkg::PH_UNI8: begin
                  if (hx[4]) begin
                     esc_val_in = uni_shift;
                     esc_big_in = uni_shift_big;
                     dcnt_in    = dcnt_ff + 4'd1;
                     if (dcnt_ff + 4'd1 >= uni_max) begin
                        uni_val = uni_shift;
                        uni_big = uni_shift_big;
                        do_uni  = 1'b1;
                     end
                  end else begin
                     do_uni  = 1'b1;
                     do_body = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         sled_pkg::KIND_EOS: begin
            case (phase_ff)
               sled_pkg::PH_IDLE: begin
               end
               sled_pkg::PH_OCT: begin
                  bst = sled_pkg::push_result(bst, sled_pkg::RES_BYTE, esc_val_ff[7:0]);
                  do_end = 1'b1;
               end
               sled_pkg::PH_HEX: begin
                  bst = sled_pkg::push_result(bst, sled_pkg::RES_BYTE,
                           (dcnt_ff == 4'd0) ? sled_pkg::CHAR_LOWER_X : esc_val_ff[7:0]);
                  do_end = 1'b1;
               end
               sled_pkg::PH_UNI4, sled_pkg::PH_UNI8: begin
                  do_uni = 1'b1;
                  do_end = 1'b1;
               end
               sled_pkg::PH_BODY: begin
                  do_flush = 1'b1;
                  do_end   = 1'b1;
               end
               default: begin
                  do_end = 1'b1;
               end
            endcase
         end
         default: begin
         end
      endcase

      // unicode escape out as utf-8; zero as a backslash, out of range as EF BF BD
      if (do_uni) begin
         if (!uni_big && uni_val == 21'd0) begin
            bst = sled_pkg::push_result(bst, sled_pkg::RES_BYTE, sled_pkg::CHAR_BACKSLASH);
         end else if (!uni_big && uni_val < sled_pkg::Utf8Lim1) begin
            bst = sled_pkg::push_result(bst, sled_pkg::RES_BYTE, uni_val[7:0]);
         end else if (!uni_big && uni_val < sled_pkg::Utf8Lim2) begin
            bst = sled_pkg::push_result(bst, sled_pkg::RES_BYTE, {3'b110, uni_val[10:6]});
            bst = sled_pkg::push_result(bst, sled_pkg::RES_BYTE, {2'b10, uni_val[5:0]});
         end else if (!uni_big && uni_val < sled_pkg::Utf8Lim3) begin
            bst = sled_pkg::push_result(bst, sled_pkg::RES_BYTE, {4'b1110, uni_val[15:12]});
            bst = sled_pkg::push_result(bst, sled_pkg::RES_BYTE, {2'b10, uni_val[11:6]});
            bst = sled_pkg::push_result(bst, sled_pkg::RES_BYTE, {2'b10, uni_val[5:0]});
         end else if (!uni_big && uni_val < sled_pkg::Utf8Lim4) begin
            bst = sled_pkg::push_result(bst, sled_pkg::RES_BYTE, {5'b11110, uni_val[20:18]});
            bst = sled_pkg::push_result(bst, sled_pkg::RES_BYTE, {2'b10, uni_val[17:12]});
            bst = sled_pkg::push_result(bst, sled_pkg::RES_BYTE, {2'b10, uni_val[11:6]});
            bst = sled_pkg::push_result(bst, sled_pkg::RES_BYTE, {2'b10, uni_val[5:0]});
         end else begin
            bst = sled_pkg::push_result(bst, sled_pkg::RES_BYTE, 8'hEF);
            bst = sled_pkg::push_result(bst, sled_pkg::RES_BYTE, 8'hBF);
            bst = sled_pkg::push_result(bst, sled_pkg::RES_BYTE, 8'hBD);
         end
         phase_in   = sled_pkg::PH_BODY;
         esc_val_in = '0;
         esc_big_in = 1'b0;
         dcnt_in    = '0;
      end

      // ordinary body byte
      if (do_body) begin
         if (swl_in) begin
            swl_in = 1'b0;
            skip   = (b == sled_pkg::CHAR_LF);
         end
         if (!skip) begin
            if (raw_ff) begin
               if (b == sled_pkg::CHAR_NUL) begin
                  do_flush = 1'b1;
                  do_end   = 1'b1;
               end else if (b == quote_ff) begin
                  if (pq_in == 2'd2) begin
                     do_end = 1'b1;
                  end else begin
                     pq_in = pq_in + 2'd1;
                  end
               end else begin
                  for (int i = 0; i < 2; i++) begin
                     if (2'(i) < pq_in) begin
                        bst = sled_pkg::push_result(bst, sled_pkg::RES_BYTE, quote_ff);
                     end
                  end
                  pq_in = '0;
                  if (is_nl) begin
                     bst = sled_pkg::push_result(bst, sled_pkg::RES_BYTE, sled_pkg::CHAR_LF);
                     line_in = line_inc;
                     swl_in  = (b == sled_pkg::CHAR_CR);
                  end else begin
                     bst = sled_pkg::push_result(bst, sled_pkg::RES_BYTE, b);
                  end
               end
            end else begin
               if (b == sled_pkg::CHAR_NUL || b == quote_ff) begin
                  do_end = 1'b1;
               end else if (is_nl) begin
                  bst = sled_pkg::push_result(bst, sled_pkg::RES_NL_ERROR, 8'd0);
                  phase_in   = sled_pkg::PH_IDLE;
                  esc_val_in = '0;
                  esc_big_in = 1'b0;
                  dcnt_in    = '0;
                  pq_in      = '0;
                  swl_in     = 1'b0;
               end else if (b == sled_pkg::CHAR_BACKSLASH) begin
                  phase_in = sled_pkg::PH_ESC;
               end else begin
                  bst = sled_pkg::push_result(bst, sled_pkg::RES_BYTE, b);
               end
            end
         end
      end

      // literal end, with any held raw quotes first
      if (do_flush) begin
         for (int i = 0; i < 2; i++) begin
            if (2'(i) < pq_in) begin
               bst = sled_pkg::push_result(bst, sled_pkg::RES_BYTE, quote_ff);
            end
         end
         pq_in = '0;
      end
      if (do_end) begin
         bst = sled_pkg::push_result(bst, end_kind, 8'd0);
         phase_in   = sled_pkg::PH_IDLE;
         esc_val_in = '0;
         esc_big_in = 1'b0;
         dcnt_in    = '0;
         pq_in      = '0;
         swl_in     = 1'b0;
      end
   end

   assign burst = bst;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= sled_pkg::PH_IDLE;
         quote_ff   <= '0;
         raw_ff     <= 1'b0;
         esc_val_ff <= '0;
         esc_big_ff <= 1'b0;
         dcnt_ff    <= '0;
         pq_ff      <= '0;
         swl_ff     <= 1'b0;
         line_ff    <= LINE_BITS'(1);
      end else if (take) begin
         phase_ff   <= phase_in;
         quote_ff   <= quote_in;
         raw_ff     <= raw_in;
         esc_val_ff <= esc_val_in;
         esc_big_ff <= esc_big_in;
         dcnt_ff    <= dcnt_in;
         pq_ff      <= pq_in;
         swl_ff     <= swl_in;
         line_ff    <= line_in;
      end
   end

endmodule

@@ design/sled_out_buf.sv @@
// ----------------------------------------------------------------------------
// sled_out_buf
// result register, holds one burst and hands it out one transaction a cycle while rsp is ready
// ----------------------------------------------------------------------------
module sled_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  sled_pkg::burst_type burst,
   output logic                free,
   sled_rsp_if.source          rsp
);

   localparam int CB = sled_pkg::CountBits;

   sled_pkg::result_type [sled_pkg::MaxResults-1:0] res_ff;
   logic [15:0]   line_ff;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic [CB-1:0] rd_ff, rd_in;
   logic          last;
   logic          pop;

   assign rsp.valid       = (rd_ff != cnt_ff);
   assign last            = (rd_ff + CB'(1) == cnt_ff);
   assign pop             = rsp.valid && rsp.ready;
   assign free            = !rsp.valid || (pop && last);
   assign rsp.result_kind = res_ff[rd_ff].kind;
   assign rsp.out_byte    = res_ff[rd_ff].data;
   assign rsp.line_number = line_ff;
   assign rsp.last_of_run = last;

   always_comb begin
      cnt_in = cnt_ff;
      rd_in  = rd_ff;
      if (load) begin
         cnt_in = burst.count;
         rd_in  = '0;
      end else if (pop) begin
         rd_in = rd_ff + CB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff  <= burst.res;
         line_ff <= burst.line;
      end
   end

endmodule

@@ design/string_literal_escape_decoder_top.sv @@
// ----------------------------------------------------------------------------
// string_literal_escape_decoder_top
// decodes the body of a quoted literal, escapes and utf-8 included
// ----------------------------------------------------------------------------
//  channel   role     handshake          payload
//  req_port  sink     valid / ready      kind, data_byte, raw_literal
//  rsp_port  source   valid / ready      result_kind, out_byte, line_number,
//                                        last_of_run
//
//  an accepted transaction waits in the input register and is decoded once
//  the single result register is free; its results (zero to five) are out
//  one per cycle from the next cycle on. one transaction a cycle while each
//  causes at most one result; a longer burst holds the decoder until its
//  last result is out. reset is synchronous; the literal closes and the line
//  count returns to one. rsp_port stalls back up through the input register.
// ----------------------------------------------------------------------------
module string_literal_escape_decoder_top #(
   parameter int LINE_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   sled_req_if.sink   req_port,
   sled_rsp_if.source rsp_port
);

   logic                item_valid;
   sled_pkg::item_type  item;
   sled_pkg::burst_type burst;
   logic                out_free;
   logic                take;

   assign take = item_valid && out_free;

   sled_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req        (req_port),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   sled_decode #(
      .LINE_BITS (LINE_BITS)
   ) u_decode (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .item  (item),
      .burst (burst)
   );

   sled_out_buf u_out_buf (
      .clock (clock),
      .reset (reset),
      .load  (take),
      .burst (burst),
      .free  (out_free),
      .rsp   (rsp_port)
   );

endmodule

@@ design/sled_checker.sv @@
// ----------------------------------------------------------------------------
// sled_checker
// port level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
module sled_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_result_kind,
   input logic [7:0]  rsp_out_byte,
   input logic [15:0] rsp_line_number,
   input logic        rsp_last_of_run
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind)
         && $stable(rsp_out_byte) && $stable(rsp_last_of_run))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid straight after reset");

   a_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind != sled_pkg::RES_BYTE)
         |-> rsp_last_of_run && (rsp_out_byte == 8'd0))
      else $error("end or error marker not last of its run");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run
         |=> rsp_valid && $stable(rsp_line_number))
      else $error("run broken or line number moved inside a run");

endmodule

bind string_literal_escape_decoder_top sled_checker u_sled_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_port.valid),
   .rsp_ready       (rsp_port.ready),
   .rsp_result_kind (rsp_port.result_kind),
   .rsp_out_byte    (rsp_port.out_byte),
   .rsp_line_number (rsp_port.line_number),
   .rsp_last_of_run (rsp_port.last_of_run)
);
